/* hw/rtl/fbpa_pkg.sv */
// Shared widths, codes and control structs of the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

   localparam int OFF_W      = 25;   // byte offset field
   localparam int SIZE_W     = 16;   // usable bytes per block register
   localparam int CNT_W      = 8;    // block_count register and counts
   localparam int STATUS_W   = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam int ALIGN_W     = 3;
   localparam int ALIGN_BYTES = 8;
   localparam int ALIGN_MASK  = 7;

   localparam int STRIDE_W = SIZE_W + 1;
   localparam int DVD_W    = OFF_W - ALIGN_W;    // dividend, stride units of 8 bytes
   localparam int DSR_W    = STRIDE_W - ALIGN_W; // divisor
   localparam int DIV_STEP = 4;                  // quotient bits per cycle
   localparam int DIV_ITER = (DVD_W + DIV_STEP - 1) / DIV_STEP;
   localparam int QUO_W    = DIV_ITER * DIV_STEP;
   localparam int DCNT_W   = $clog2(DIV_ITER);

   localparam int GROUP_SIZE = 16;
   localparam int GLOC_W     = 4;

   localparam int RST_BLOCK_SIZE  = 64;
   localparam int RST_BLOCK_COUNT = 16;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_NULL    = 3'd2,
      ST_INVALID = 3'd3,
      ST_DOUBLE  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SIZE  = 1'b0,
      CSR_BLOCK_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;      // capture request, precheck free offset
      logic scan;      // per-group first-free search
      logic pick;      // group select and index * stride
      logic div_step;  // one divider iteration
      logic fin_alloc; // commit allocate, load response
      logic fin_free;  // commit free, load response
   } cmd_type;

   typedef struct packed {
      logic out_free;  // response register can take a new result
   } sts_type;

endpackage

`default_nettype wire

/* hw/rtl/fbpa_channels.sv */
// Request and response channel interfaces of the pool allocator.
`default_nettype none

interface fbpa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [fbpa_pkg::OFF_W-1:0]    free_offset;

   modport source (output valid, output operation, output free_offset, input ready);
   modport sink   (input valid, input operation, input free_offset, output ready);
endinterface

interface fbpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fbpa_pkg::STATUS_W-1:0] status;
   logic [fbpa_pkg::OFF_W-1:0]    block_offset;
   logic [fbpa_pkg::CNT_W-1:0]    free_blocks;

   modport source (output valid, output status, output block_offset, output free_blocks,
                   input ready);
   modport sink   (input valid, input status, input block_offset, input free_blocks,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/fbpa_ctrl.sv */
// Sequencer of the pool allocator: request intake, search and divide steps.
`default_nettype none

module fbpa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_free,
   output logic                   req_ready,
   input  wire fbpa_pkg::sts_type sts,
   output fbpa_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_FIN_ALLOC,
      S_DIV,
      S_FIN_FREE
   } state_type;

   state_type                    state_ff, state_in;
   logic [fbpa_pkg::DCNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic                         accept;
   logic                         div_last;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign div_last  = (div_cnt_ff == fbpa_pkg::DCNT_W'(fbpa_pkg::DIV_ITER - 1));

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load   = 1'b1;
               div_cnt_in = '0;
               state_in   = req_free ? S_DIV : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_FIN_ALLOC;
         end
         S_FIN_ALLOC: begin
            if (sts.out_free) begin
               cmd.fin_alloc = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_last) begin
               div_cnt_in = '0;
               state_in   = S_FIN_FREE;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_FIN_FREE: begin
            if (sts.out_free) begin
               cmd.fin_free = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in   = S_IDLE;
            div_cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start work");

   a_div_cnt_only_in_div: assert property (@(posedge clock) disable iff (reset)
      (div_cnt_ff != '0) |-> (state_ff == S_DIV))
      else $error("divide counter running outside divide");
`endif

endmodule

`default_nettype wire

/* hw/rtl/fbpa_dpath.sv */
// Datapath of the pool allocator: block map, search tree, divider, response.
`default_nettype none

module fbpa_dpath #(
   parameter int MAX_BLOCKS   = 256,
   parameter int NODE_BYTES   = 16,
   parameter int HEADER_BYTES = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [fbpa_pkg::OFF_W-1:0]       req_free_offset,
   input  wire fbpa_pkg::cmd_type                cmd,
   output fbpa_pkg::sts_type                     sts,
   fbpa_rsp_if.source                            rsp_if
);

   localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int NGRP       = (MAX_BLOCKS + fbpa_pkg::GROUP_SIZE - 1) / fbpa_pkg::GROUP_SIZE;
   localparam int PAD_BLOCKS = NGRP * fbpa_pkg::GROUP_SIZE;
   localparam int BASE       = HEADER_BYTES + NODE_BYTES;
   localparam int STRIDE_RST = (fbpa_pkg::RST_BLOCK_SIZE + NODE_BYTES + fbpa_pkg::ALIGN_MASK)
                               / fbpa_pkg::ALIGN_BYTES * fbpa_pkg::ALIGN_BYTES;
   localparam int COUNT_RST  = (fbpa_pkg::RST_BLOCK_COUNT > MAX_BLOCKS) ?
                               MAX_BLOCKS : fbpa_pkg::RST_BLOCK_COUNT;
   localparam int PROD_W     = IDX_W + fbpa_pkg::STRIDE_W;

   // configuration
   logic [fbpa_pkg::STRIDE_W-1:0]  stride_ff, stride_in;
   logic [fbpa_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [fbpa_pkg::STRIDE_W-1:0]  stride_sum;
   logic [fbpa_pkg::CNT_W-1:0]     wr_count;

   // block map
   logic [MAX_BLOCKS-1:0]          in_use_ff, in_use_in;
   logic [fbpa_pkg::CNT_W-1:0]     used_ff, used_in;

   // allocate search
   logic [PAD_BLOCKS-1:0]          in_use_pad;
   logic [PAD_BLOCKS-1:0]          cand;
   logic [NGRP-1:0]                grp_hit_ff, grp_hit_in;
   logic [fbpa_pkg::GLOC_W-1:0]    grp_loc_ff [NGRP];
   logic [fbpa_pkg::GLOC_W-1:0]    grp_loc_in [NGRP];
   logic                           found_ff, found_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [PROD_W-1:0]              prod_ff;
   int                             pick_pos;

   // free check and divider
   logic [fbpa_pkg::OFF_W-1:0]     rel;
   logic                           is_null_ff;
   logic                           bad_ff;
   logic [fbpa_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [fbpa_pkg::DSR_W-1:0]     rem_ff, rem_in;
   logic [fbpa_pkg::DSR_W-1:0]     dsr;
   logic [fbpa_pkg::DSR_W:0]       trial;
   logic                           ge;

   // response
   logic                           rsp_valid_ff, rsp_valid_in;
   fbpa_pkg::status_type           status_ff, status_in;
   logic [fbpa_pkg::OFF_W-1:0]     offset_ff, offset_in;
   logic [fbpa_pkg::CNT_W-1:0]     free_ff, free_in;
   logic                           idx_ok;
   logic [IDX_W-1:0]               free_idx;

   // ---- configuration ----
   assign stride_sum = fbpa_pkg::STRIDE_W'(csr_wdata[fbpa_pkg::SIZE_W-1:0])
                     + fbpa_pkg::STRIDE_W'(NODE_BYTES + fbpa_pkg::ALIGN_MASK);
   assign wr_count   = csr_wdata[fbpa_pkg::CNT_W-1:0];

   always_comb begin
      stride_in = stride_ff;
      count_in  = count_ff;
      if (csr_we) begin
         case (fbpa_pkg::csr_index_type'(csr_index))
            fbpa_pkg::CSR_BLOCK_SIZE: begin
               stride_in = {stride_sum[fbpa_pkg::STRIDE_W-1:fbpa_pkg::ALIGN_W],
                            fbpa_pkg::ALIGN_W'(0)};
            end
            fbpa_pkg::CSR_BLOCK_COUNT: begin
               count_in = (int'(wr_count) > MAX_BLOCKS) ?
                          fbpa_pkg::CNT_W'(MAX_BLOCKS) : wr_count;
            end
            default: begin
               stride_in = stride_ff;
            end
         endcase
      end
   end

   // ---- allocate: first-free search, two registered levels ----
   assign in_use_pad = PAD_BLOCKS'(in_use_ff);

   always_comb begin
      for (int j = 0; j < PAD_BLOCKS; j++) begin
         cand[j] = !in_use_pad[j] && (j < int'(count_ff));
      end
      for (int g = 0; g < NGRP; g++) begin
         grp_hit_in[g] = |cand[g*fbpa_pkg::GROUP_SIZE +: fbpa_pkg::GROUP_SIZE];
         grp_loc_in[g] = '0;
         for (int k = fbpa_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
            if (cand[g*fbpa_pkg::GROUP_SIZE + k]) begin
               grp_loc_in[g] = fbpa_pkg::GLOC_W'(k);
            end
         end
      end
   end

   always_comb begin
      found_in = 1'b0;
      pick_pos = 0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            found_in = 1'b1;
            pick_pos = g * fbpa_pkg::GROUP_SIZE + int'(grp_loc_ff[g]);
         end
      end
      idx_in = IDX_W'(pick_pos);
   end

   // ---- free: offset precheck and restoring divide by stride/8 ----
   assign rel = req_free_offset - fbpa_pkg::OFF_W'(BASE);
   assign dsr = stride_ff[fbpa_pkg::STRIDE_W-1:fbpa_pkg::ALIGN_W];

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      ge     = 1'b0;
      for (int s = 0; s < fbpa_pkg::DIV_STEP; s++) begin
         trial = {rem_in, quo_in[fbpa_pkg::QUO_W-1]};
         ge    = (trial >= {1'b0, dsr});
         if (ge) begin
            trial = trial - {1'b0, dsr};
         end
         rem_in = trial[fbpa_pkg::DSR_W-1:0];
         quo_in = {quo_in[fbpa_pkg::QUO_W-2:0], ge};
      end
   end

   // ---- commit and response ----
   assign idx_ok   = (quo_ff < fbpa_pkg::QUO_W'(count_ff));
   assign free_idx = quo_ff[IDX_W-1:0];

   always_comb begin
      in_use_in = in_use_ff;
      used_in   = used_ff;
      status_in = status_ff;
      offset_in = offset_ff;
      if (cmd.fin_alloc) begin
         offset_in = '0;
         if (found_ff) begin
            in_use_in[idx_ff] = 1'b1;
            used_in           = used_ff + 1'b1;
            status_in         = fbpa_pkg::ST_OK;
            offset_in         = fbpa_pkg::OFF_W'(prod_ff + PROD_W'(BASE));
         end else begin
            status_in = fbpa_pkg::ST_EMPTY;
         end
      end else if (cmd.fin_free) begin
         offset_in = '0;
         if (is_null_ff) begin
            status_in = fbpa_pkg::ST_NULL;
         end else if (bad_ff || (rem_ff != '0) || !idx_ok) begin
            status_in = fbpa_pkg::ST_INVALID;
         end else if (!in_use_ff[free_idx]) begin
            status_in = fbpa_pkg::ST_DOUBLE;
         end else begin
            in_use_in[free_idx] = 1'b0;
            used_in             = (used_ff != '0) ? used_ff - 1'b1 : '0;
            status_in           = fbpa_pkg::ST_OK;
         end
      end
      // any register write rebuilds the pool
      if (csr_we) begin
         in_use_in = '0;
         used_in   = '0;
      end
      free_in = (count_ff > used_in) ? count_ff - used_in : '0;
   end

   assign sts.out_free = !rsp_valid_ff || rsp_if.ready;
   assign rsp_valid_in = (cmd.fin_alloc || cmd.fin_free) || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff    <= fbpa_pkg::STRIDE_W'(STRIDE_RST);
         count_ff     <= fbpa_pkg::CNT_W'(COUNT_RST);
         in_use_ff    <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stride_ff    <= stride_in;
         count_ff     <= count_in;
         in_use_ff    <= in_use_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         grp_hit_ff <= grp_hit_in;
         grp_loc_ff <= grp_loc_in;
      end
      if (cmd.pick) begin
         found_ff <= found_in;
         idx_ff   <= idx_in;
         prod_ff  <= PROD_W'(idx_in) * PROD_W'(stride_ff);
      end
      if (cmd.load) begin
         is_null_ff <= (req_free_offset == '0);
         bad_ff     <= (req_free_offset < fbpa_pkg::OFF_W'(BASE))
                    || (rel[fbpa_pkg::ALIGN_W-1:0] != '0);
         quo_ff     <= fbpa_pkg::QUO_W'(rel[fbpa_pkg::OFF_W-1:fbpa_pkg::ALIGN_W]);
         rem_ff     <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.fin_alloc || cmd.fin_free) begin
         status_ff <= status_in;
         offset_ff <= offset_in;
         free_ff   <= free_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.block_offset = offset_ff;
   assign rsp_if.free_blocks  = free_ff;

`ifndef SYNTHESIS
   a_used_matches_map: assert property (@(posedge clock) disable iff (reset)
      $countones(in_use_ff) == int'(used_ff))
      else $error("used count out of step with block map");

   a_used_within_pool: assert property (@(posedge clock) disable iff (reset)
      used_ff <= count_ff)
      else $error("more blocks in use than the pool holds");
`endif

endmodule

`default_nettype wire

/* hw/rtl/fixed_block_pool_allocator_core.sv */
// Top level of the fixed-size block pool allocator.
//
//   channel  dir  transfer when          payload
//   req_if   in   valid && ready         operation, free_offset
//   rsp_if   out  valid && ready         status, block_offset, free_blocks
//   csr_*    in   csr_we high            csr_index, csr_wdata (no read-back)
//
// Allocate: the response follows the request transfer through group search,
//   group pick with index*stride, and commit.
// Free: the request transfer also does the offset precheck; the response then
//   follows through 6 divider steps at 4 quotient bits each, and commit.
// The restoring divider by stride/8 sets the free latency; one request is in
//   flight at a time.
// A new request is taken while the previous response still waits in the
//   output register; commit stalls only if that register is still full.
// Reset (synchronous) and any register write free every block.
`default_nettype none

module fixed_block_pool_allocator_core #(
   parameter int MAX_BLOCKS   = 256,
   parameter int NODE_BYTES   = 16,
   parameter int HEADER_BYTES = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   fbpa_req_if.sink                              req_if,
   fbpa_rsp_if.source                            rsp_if,
   input  wire logic                             csr_we,
   input  wire logic [fbpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fbpa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fbpa_pkg::cmd_type  cmd;   // sequencer -> datapath
   fbpa_pkg::sts_type  sts;   // datapath -> sequencer
   logic               ctrl_ready;
   logic               req_free;

   assign req_free     = (req_if.operation == fbpa_pkg::OP_FREE);
   assign req_if.ready = ctrl_ready;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_free  (req_free),
      .req_ready (ctrl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbpa_dpath #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .NODE_BYTES   (NODE_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_free_offset (req_if.free_offset),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_if          (rsp_if)
   );

endmodule

`default_nettype wire

/* sim/tb_fixed_block_pool_allocator_core.sv */
// Self-checking testbench of the fixed block pool allocator core.
`default_nettype none

module tb_fixed_block_pool_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import fbpa_pkg::*;

   localparam int POOL_MAX = 256;
   localparam int NODE_B   = 16;
   localparam int HEADER_B = 24;

   typedef struct packed {
      status_type        status;
      logic [OFF_W-1:0]  block_offset;
      logic [CNT_W-1:0]  free_blocks;
   } reply_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fbpa_req_if req_bus();
   fbpa_rsp_if rsp_bus();

   fixed_block_pool_allocator_core #(
      .MAX_BLOCKS  (POOL_MAX),
      .NODE_BYTES  (NODE_B),
      .HEADER_BYTES(HEADER_B)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_bus),
      .rsp_if   (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow of the pool: settings, occupancy and the offsets handed out.
   logic [SIZE_W-1:0]  cfg_size;
   logic [CNT_W-1:0]   cfg_count;
   bit                 block_busy [POOL_MAX];
   int                 busy_count;
   logic [OFF_W-1:0]   held_offsets [$];

   reply_type          awaited_replies [$];
   int                 errors;
   int                 idle_pct;
   int                 stall_pct;
   int                 request_count;
   int                 settings_used;
   int                 status_tally [5];

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      #4_000_000;
      $display("Timeout with %0d replies outstanding", awaited_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver side: stall the reply channel at the configured rate.
   always @(negedge clock) rsp_bus.ready = ($urandom_range(99) >= stall_pct);

   function automatic int unsigned pool_stride();
      return (int'(cfg_size) + NODE_B + ALIGN_MASK) & ~ALIGN_MASK;
   endfunction

   function automatic logic [OFF_W-1:0] user_offset(input int unsigned idx);
      return OFF_W'(HEADER_B + idx * pool_stride() + NODE_B);
   endfunction

   // Any register write rebuilds the pool with every block free.
   function automatic void apply_register(input csr_index_type idx,
                                          input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_BLOCK_SIZE) cfg_size = data;
      else cfg_count = data[CNT_W-1:0];
      foreach (block_busy[i]) block_busy[i] = 1'b0;
      busy_count = 0;
      held_offsets.delete();
   endfunction

   // Next reply of the allocator for one request; updates the shadow pool.
   function automatic reply_type allocator_reply(input op_type op,
                                                 input logic [OFF_W-1:0] off);
      reply_type   r;
      int unsigned stride;
      int unsigned rel;
      int unsigned idx;
      int          pool_n;
      int          slot;
      int          hit [$];
      r.status       = ST_OK;
      r.block_offset = '0;
      pool_n         = int'(cfg_count);
      stride         = pool_stride();
      if (op == OP_ALLOC) begin
         slot = -1;
         for (int i = 0; i < pool_n; i++) begin
            if (!block_busy[i]) begin
               slot = i;
               break;
            end
         end
         if (slot >= 0) begin
            block_busy[slot] = 1'b1;
            busy_count++;
            r.block_offset = user_offset(slot);
            held_offsets.push_back(r.block_offset);
         end else begin
            r.status = ST_EMPTY;
         end
      end else if (off == '0) begin
         r.status = ST_NULL;
      end else if (off < HEADER_B + NODE_B) begin
         r.status = ST_INVALID;
      end else begin
         rel = off - (HEADER_B + NODE_B);
         idx = rel / stride;
         if (rel % stride != 0 || idx >= pool_n) begin
            r.status = ST_INVALID;
         end else if (!block_busy[idx]) begin
            r.status = ST_DOUBLE;
         end else begin
            block_busy[idx] = 1'b0;
            busy_count = (busy_count > 0) ? busy_count - 1 : 0;
            hit = held_offsets.find_first_index(x) with (x == off);
            if (hit.size() != 0) held_offsets.delete(hit[0]);
         end
      end
      r.free_blocks = (pool_n > busy_count) ? CNT_W'(pool_n - busy_count) : '0;
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // At each rising edge: check a reply transfer first, then predict for a
   // request transfer (a request never completes in the edge it is taken).
   always @(posedge clock) begin : reply_check
      reply_type want;
      reply_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status       = status_type'(rsp_bus.status);
            got.block_offset = rsp_bus.block_offset;
            got.free_blocks  = rsp_bus.free_blocks;
            if (awaited_replies.size() == 0) begin
               errors++;
               $display("%0t: reply transfer with none expected, status %0d offset %0d",
                        $time, got.status, got.block_offset);
            end else begin
               want = awaited_replies.pop_front();
               check_field("status", want.status, got.status);
               check_field("block_offset", want.block_offset, got.block_offset);
               check_field("free_blocks", want.free_blocks, got.free_blocks);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = allocator_reply(op_type'(req_bus.operation), req_bus.free_offset);
            awaited_replies.push_back(want);
            status_tally[want.status]++;
            request_count++;
         end
      end
   end

   task automatic send_request(input op_type op, input logic [OFF_W-1:0] off);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 24) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.operation   = op;
      req_bus.free_offset = off;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Hold the sender off until every expected reply has come back.
   task automatic wait_replies();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (awaited_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      apply_register(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_count(input int value);
      write_reg(CSR_BLOCK_COUNT, {8'($urandom), 8'(value)});
   endtask

   // Mostly well-formed traffic (allocate, free what was handed out) mixed
   // with double frees, misaligned, beyond-pool, null and arbitrary offsets.
   function automatic void pick_request(output op_type op, output logic [OFF_W-1:0] off);
      int unsigned roll;
      int unsigned span;
      roll = $urandom_range(99);
      span = (cfg_count == 0) ? 1 : int'(cfg_count);
      op   = OP_FREE;
      off  = OFF_W'($urandom);
      if (roll < 45) begin
         op = OP_ALLOC;
      end else if (roll < 80) begin
         if (held_offsets.size() == 0) op = OP_ALLOC;
         else off = held_offsets[$urandom_range(held_offsets.size() - 1)];
      end else if (roll < 86) begin
         off = user_offset($urandom_range(span - 1));
      end else if (roll < 91) begin
         off = user_offset($urandom_range(span - 1))
             + OFF_W'($urandom_range(pool_stride() - 1, 1));
      end else if (roll < 94) begin
         off = user_offset(cfg_count + $urandom_range(3));
      end else if (roll < 96) begin
         off = '0;
      end else if (roll < 98) begin
         off = OFF_W'($urandom_range(HEADER_B + NODE_B - 1, 1));
      end
   endfunction

   task automatic random_pool_setting();
      int size_v;
      int count_v;
      case ($urandom_range(3))
         0: size_v = $urandom_range(64, 1);
         1: size_v = $urandom_range(65535);
         2: size_v = 65535;
         default: size_v = $urandom_range(300);
      endcase
      case ($urandom_range(5))
         0, 1, 2: count_v = $urandom_range(12, 1);
         3: count_v = $urandom_range(255, 13);
         4: count_v = 255;
         default: count_v = $urandom_range(3);
      endcase
      if ($urandom_range(1)) begin
         write_reg(CSR_BLOCK_SIZE, 16'(size_v));
         write_count(count_v);
      end else begin
         write_count(count_v);
         write_reg(CSR_BLOCK_SIZE, 16'(size_v));
      end
      settings_used++;
   endtask

   // Reset settings: 16 blocks of 64 bytes, stride 80.
   task automatic test_default_pool();
      idle_pct  = 0;
      stall_pct = 0;
      send_request(OP_ALLOC, '1);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, OFF_W'($urandom));
      send_request(OP_FREE, user_offset(1));
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, '0);
      send_request(OP_FREE, 25'd1);
      send_request(OP_FREE, user_offset(1) + 1'b1);
      send_request(OP_FREE, '1);
      send_request(OP_FREE, user_offset(16));
      send_request(OP_FREE, user_offset(15));
      send_request(OP_FREE, user_offset(0));
      send_request(OP_FREE, user_offset(0));
   endtask

   task automatic test_setting_extremes();
      wait_replies();
      // single tiny block: exhaustion after one allocation
      write_reg(CSR_BLOCK_SIZE, 16'd1);
      write_count(1);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, user_offset(0));
      send_request(OP_FREE, user_offset(1));
      wait_replies();
      // largest blocks and count: widest offsets
      write_reg(CSR_BLOCK_SIZE, 16'hFFFF);
      write_count(255);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, user_offset(1));
      send_request(OP_FREE, user_offset(254));
      wait_replies();
      // empty pool
      write_count(0);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, user_offset(0));
      wait_replies();
      // zero-byte blocks, stride equals the node header
      write_reg(CSR_BLOCK_SIZE, 16'd0);
      write_count(2);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, '0);
      send_request(OP_FREE, user_offset(1));
      settings_used += 4;
   endtask

   task automatic test_random_traffic(input int items, input int idle, input int stall);
      op_type           op;
      logic [OFF_W-1:0] off;
      wait_replies();
      random_pool_setting();
      idle_pct  = idle;
      stall_pct = stall;
      for (int n = 0; n < items; n++) begin
         if (n == items / 2) wait_replies();
         pick_request(op, off);
         send_request(op, off);
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_BLOCK_SIZE;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_ALLOC;
      req_bus.free_offset = '0;
      rsp_bus.ready       = 1'b0;
      errors              = 0;
      idle_pct            = 0;
      stall_pct           = 0;
      request_count       = 0;
      settings_used       = 1;
      cfg_size            = SIZE_W'(RST_BLOCK_SIZE);
      cfg_count           = CNT_W'(RST_BLOCK_COUNT);
      busy_count          = 0;
      foreach (block_busy[i]) block_busy[i] = 1'b0;
      foreach (status_tally[i]) status_tally[i] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_pool();
      test_setting_extremes();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: test_random_traffic(210, 0, 0);
            1: test_random_traffic(210, 46, 0);
            2: test_random_traffic(210, 0, 46);
            default: test_random_traffic(210, 24, 24);
         endcase
      end

      wait_replies();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests across %0d pool settings", request_count, settings_used);
      $display("Replies: ok %0d, empty %0d, null %0d, invalid %0d, double free %0d",
               status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_NULL],
               status_tally[ST_INVALID], status_tally[ST_DOUBLE]);
      if (errors == 0 && awaited_replies.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* fixed_block_pool_allocator_core.f */
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_channels.sv
hw/rtl/fbpa_ctrl.sv
hw/rtl/fbpa_dpath.sv
hw/rtl/fixed_block_pool_allocator_core.sv
sim/tb_fixed_block_pool_allocator_core.sv
